>>> rtl/ste_pkg.sv
// Shared types and constants for the semaphore table engine.
// Holds the command and status codes, the request and response structs and
// the controller state type. Depends on nothing.
package ste_pkg;

   localparam int NUM_SEMS_DEF   = 16;
   localparam int WAIT_DEPTH_DEF = 8;
   localparam int COUNT_BITS_DEF = 16;
   localparam int TASK_W         = 8;

   typedef enum logic [2:0] {
      CMD_CREATE  = 3'd0,
      CMD_DELETE  = 3'd1,
      CMD_WAIT    = 3'd2,
      CMD_TRYWAIT = 3'd3,
      CMD_POST    = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      STAT_OK         = 3'd0,
      STAT_BLOCKED    = 3'd1,
      STAT_NO_SEM     = 3'd2,
      STAT_NO_SLOT    = 3'd3,
      STAT_QUEUE_FULL = 3'd4
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      logic [2:0]        cmd;
      logic [3:0]        sem_id;
      logic [15:0]       init_count;
      logic              sem_kind;
      logic [TASK_W-1:0] task_id;
   } req_type;

   typedef struct packed {
      logic [2:0]        status;
      logic [3:0]        new_id;
      logic              woke_valid;
      logic [TASK_W-1:0] woke_task;
   } rsp_type;

endpackage

>>> rtl/ste_ram.sv
// Simple dual-port synchronous RAM with registered read.
// Used for the semaphore entry table and the waiter queues; uses ste_pkg
// for default sizes.
module ste_ram import ste_pkg::*; #(
   parameter int WIDTH = TASK_W,
   parameter int DEPTH = NUM_SEMS_DEF * WAIT_DEPTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> rtl/semaphore_table_engine_core.sv
// Semaphore table engine: create, delete, wait, trywait and post commands.
// Accept registers the request; the execute state registers the response, and a
// response not yet taken delays it. Commands run one at a time, as set by the
// read-then-write pass over entry and waiter RAM (read at accept, write in execute).
// Reset clears the in-use bits, the controller and the response valid at
// once; no clearing pass, the RAMs need none.
module semaphore_table_engine_core import ste_pkg::*; #(
   parameter int NUM_SEMS   = NUM_SEMS_DEF,
   parameter int WAIT_DEPTH = WAIT_DEPTH_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int SLOT_W  = $clog2(NUM_SEMS);
   localparam int POS_W   = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
   localparam int FILL_W  = $clog2(WAIT_DEPTH + 1);
   localparam int WQ_D    = NUM_SEMS * WAIT_DEPTH;
   localparam int WADDR_W = (WQ_D > 1) ? $clog2(WQ_D) : 1;
   localparam int ENTRY_W = COUNT_BITS + 1;

   localparam logic [COUNT_BITS-1:0] CNT_MAX  = {COUNT_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] CNT_ONE  = COUNT_BITS'(1);
   localparam logic [POS_W-1:0]      POS_LAST = POS_W'(WAIT_DEPTH - 1);
   localparam logic [FILL_W-1:0]     FILL_MAX = FILL_W'(WAIT_DEPTH);
   localparam logic [WADDR_W-1:0]    WQ_STEP  = WADDR_W'(WAIT_DEPTH);

   state_type state_ff, state_in;
   req_type   req_ff;
   logic      rsp_valid_ff;
   rsp_type   rsp_ff, rsp_in;

   logic [NUM_SEMS-1:0] used_ff;
   logic [POS_W-1:0]    head_ff [NUM_SEMS];
   logic [FILL_W-1:0]   fill_ff [NUM_SEMS];

   logic accept, exec_go;

   // request side addressing
   logic [SLOT_W-1:0]  s_req;
   logic [WADDR_W-1:0] wq_rd_addr;

   // execute side
   logic [SLOT_W-1:0]     s_ff;
   logic                  live;
   logic [ENTRY_W-1:0]    entry_rd;
   logic                  kind_rd;
   logic [COUNT_BITS-1:0] count_rd;
   logic [TASK_W-1:0]     wq_rd;
   logic [POS_W-1:0]      head_cur;
   logic [FILL_W-1:0]     fill_cur;
   logic                  can_take;
   logic [COUNT_BITS-1:0] taken_count;
   logic [COUNT_BITS-1:0] init_sat;
   logic [POS_W:0]        tail_sum;
   logic [POS_W-1:0]      tail_pos;
   logic [POS_W-1:0]      head_next;

   logic                  free_found;
   logic [SLOT_W-1:0]     free_idx;

   logic                  entry_we;
   logic [SLOT_W-1:0]     entry_waddr;
   logic                  new_kind;
   logic [COUNT_BITS-1:0] new_count;
   logic                  meta_we;
   logic [POS_W-1:0]      new_head;
   logic [FILL_W-1:0]     new_fill;
   logic                  used_set, used_clr;
   logic                  wq_we;
   logic [WADDR_W-1:0]    wq_wr_addr;

   // ---------------------------------------------------------------- control
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req_valid) state_in = S_EXEC;
         S_EXEC:  if (!rsp_valid_ff || rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      exec_go   = 1'b0;
      case (state_ff)
         S_IDLE:  req_ready = 1'b1;
         S_EXEC:  exec_go   = !rsp_valid_ff || rsp_ready;
         default: req_ready = 1'b0;
      endcase
   end

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (exec_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (exec_go) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------------------------------------------------------- memories
   assign s_req      = SLOT_W'(req_data.sem_id);
   assign wq_rd_addr = WADDR_W'(s_req) * WQ_STEP + WADDR_W'(head_ff[s_req]);

   ste_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_SEMS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (entry_we && exec_go),
      .wr_addr (entry_waddr),
      .wr_data ({new_kind, new_count}),
      .rd_en   (accept),
      .rd_addr (s_req),
      .rd_data (entry_rd)
   );

   ste_ram #(
      .WIDTH (TASK_W),
      .DEPTH (WQ_D)
   ) u_waiter_ram (
      .clock   (clock),
      .wr_en   (wq_we && exec_go),
      .wr_addr (wq_wr_addr),
      .wr_data (req_ff.task_id),
      .rd_en   (accept),
      .rd_addr (wq_rd_addr),
      .rd_data (wq_rd)
   );

   // ---------------------------------------------------------------- execute
   assign s_ff     = SLOT_W'(req_ff.sem_id);
   assign live     = (32'(req_ff.sem_id) < NUM_SEMS) && used_ff[s_ff];
   assign kind_rd  = entry_rd[COUNT_BITS];
   assign count_rd = entry_rd[COUNT_BITS-1:0];
   assign head_cur = head_ff[s_ff];
   assign fill_cur = fill_ff[s_ff];

   // binary semaphores are taken only at exactly one
   assign can_take    = kind_rd ? (count_rd == CNT_ONE) : (count_rd != '0);
   assign taken_count = kind_rd ? '0 : count_rd - CNT_ONE;

   assign init_sat = (32'(req_ff.init_count) > 32'(CNT_MAX)) ?
                     CNT_MAX : COUNT_BITS'(req_ff.init_count);

   // tail position stays below twice the depth: one compare and subtract
   assign tail_sum   = (POS_W + 1)'(head_cur) + (POS_W + 1)'(fill_cur);
   assign tail_pos   = (32'(tail_sum) >= WAIT_DEPTH) ?
                       POS_W'(32'(tail_sum) - WAIT_DEPTH) : POS_W'(tail_sum);
   assign head_next  = (head_cur == POS_LAST) ? '0 : head_cur + POS_W'(1);
   assign wq_wr_addr = WADDR_W'(s_ff) * WQ_STEP + WADDR_W'(tail_pos);

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = NUM_SEMS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
      end
   end

   always_comb begin
      entry_we    = 1'b0;
      entry_waddr = s_ff;
      new_kind    = kind_rd;
      new_count   = count_rd;
      meta_we     = 1'b0;
      new_head    = head_cur;
      new_fill    = fill_cur;
      used_set    = 1'b0;
      used_clr    = 1'b0;
      wq_we       = 1'b0;
      rsp_in      = '0;
      rsp_in.status = STAT_OK;
      case (req_ff.cmd)
         CMD_CREATE: begin
            if (free_found) begin
               entry_we      = 1'b1;
               entry_waddr   = free_idx;
               new_kind      = req_ff.sem_kind;
               new_count     = init_sat;
               meta_we       = 1'b1;
               new_head      = '0;
               new_fill      = '0;
               used_set      = 1'b1;
               rsp_in.new_id = 4'(free_idx);
            end else begin
               rsp_in.status = STAT_NO_SLOT;
            end
         end
         CMD_DELETE: begin
            if (live) begin
               used_clr = 1'b1;
            end else begin
               rsp_in.status = STAT_NO_SEM;
            end
         end
         CMD_WAIT: begin
            if (!live) begin
               rsp_in.status = STAT_NO_SEM;
            end else if (can_take) begin
               entry_we  = 1'b1;
               new_count = taken_count;
            end else if (fill_cur == FILL_MAX) begin
               rsp_in.status = STAT_QUEUE_FULL;
            end else begin
               wq_we         = 1'b1;
               meta_we       = 1'b1;
               new_fill      = fill_cur + FILL_W'(1);
               rsp_in.status = STAT_BLOCKED;
            end
         end
         CMD_TRYWAIT: begin
            if (!live) begin
               rsp_in.status = STAT_NO_SEM;
            end else if (can_take) begin
               entry_we  = 1'b1;
               new_count = taken_count;
            end else begin
               rsp_in.status = STAT_BLOCKED;
            end
         end
         CMD_POST: begin
            if (!live) begin
               rsp_in.status = STAT_NO_SEM;
            end else if (fill_cur != '0) begin
               // release the oldest waiter
               meta_we           = 1'b1;
               new_head          = head_next;
               new_fill          = fill_cur - FILL_W'(1);
               rsp_in.woke_valid = 1'b1;
               rsp_in.woke_task  = wq_rd;
            end else if (!kind_rd) begin
               entry_we = 1'b1;
               if (count_rd != CNT_MAX) begin
                  new_count = count_rd + CNT_ONE;
               end
            end else begin
               entry_we  = 1'b1;
               new_count = CNT_ONE;
            end
         end
         default: rsp_in.status = STAT_NO_SEM;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (exec_go) begin
         if (used_set) begin
            used_ff[free_idx] <= 1'b1;
         end
         if (used_clr) begin
            used_ff[s_ff] <= 1'b0;
         end
      end
   end

   // queue pointers are rewritten by create, so they need no reset
   always_ff @(posedge clock) begin
      if (exec_go && meta_we) begin
         head_ff[entry_waddr] <= new_head;
         fill_ff[entry_waddr] <= new_fill;
      end
   end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for semaphore_table_engine_core: a directed command table, then
// random command traffic, each response checked against a typed-in expectation or a local model.
// Depends on ste_pkg and the core RTL only.
module tb_top;
   import ste_pkg::*;

   localparam logic [2:0]  CMD_UNDEF_LO = 3'd5;
   localparam logic [2:0]  CMD_UNDEF_HI = 3'd7;
   localparam logic [15:0] COUNT_TOP    = '1;
   localparam int          HEAD_W       = $clog2(WAIT_DEPTH_DEF);
   localparam int          RAND_ITEMS   = 820;
   localparam int          TAIL_ITEMS   = 100;

   typedef struct packed {
      req_type    req;
      logic [3:0] reps;
      logic       typed;
      rsp_type    rsp;
   } dir_row_type;

   // cmd, sem_id, init_count, sem_kind, task_id / repeats / expectation typed in / expectation
   localparam dir_row_type DIR_TAB [23] = '{
      '{'{CMD_POST,     4'd0,  16'h0000, 1'b0, 8'h00}, 4'd1, 1'b1,
        '{STAT_NO_SEM,  4'd0,  1'b0, 8'h00}},
      '{'{CMD_WAIT,     4'd15, 16'h0000, 1'b0, 8'hFF}, 4'd1, 1'b1,
        '{STAT_NO_SEM,  4'd0,  1'b0, 8'h00}},
      '{'{CMD_UNDEF_HI, 4'd15, 16'hFFFF, 1'b1, 8'hFF}, 4'd1, 1'b1,
        '{STAT_NO_SEM,  4'd0,  1'b0, 8'h00}},
      '{'{CMD_DELETE,   4'd3,  16'h0000, 1'b0, 8'h00}, 4'd1, 1'b1,
        '{STAT_NO_SEM,  4'd0,  1'b0, 8'h00}},
      '{'{CMD_CREATE,   4'd0,  16'hFFFF, 1'b0, 8'h00}, 4'd1, 1'b1,
        '{STAT_OK,      4'd0,  1'b0, 8'h00}},
      '{'{CMD_CREATE,   4'd0,  16'h0000, 1'b1, 8'h00}, 4'd1, 1'b1,
        '{STAT_OK,      4'd1,  1'b0, 8'h00}},
      // binary semaphore holding a value that is neither zero nor one
      '{'{CMD_CREATE,   4'd0,  16'h0002, 1'b1, 8'h00}, 4'd1, 1'b1,
        '{STAT_OK,      4'd2,  1'b0, 8'h00}},
      '{'{CMD_TRYWAIT,  4'd1,  16'h0000, 1'b0, 8'h01}, 4'd1, 1'b1,
        '{STAT_BLOCKED, 4'd0,  1'b0, 8'h00}},
      '{'{CMD_TRYWAIT,  4'd2,  16'h0000, 1'b0, 8'h02}, 4'd1, 1'b1,
        '{STAT_BLOCKED, 4'd0,  1'b0, 8'h00}},
      '{'{CMD_POST,     4'd2,  16'h0000, 1'b0, 8'h03}, 4'd1, 1'b1,
        '{STAT_OK,      4'd0,  1'b0, 8'h00}},
      '{'{CMD_TRYWAIT,  4'd2,  16'h0000, 1'b0, 8'h04}, 4'd1, 1'b1,
        '{STAT_OK,      4'd0,  1'b0, 8'h00}},
      // post on a saturated count, then take one
      '{'{CMD_POST,     4'd0,  16'h0000, 1'b0, 8'h05}, 4'd1, 1'b1,
        '{STAT_OK,      4'd0,  1'b0, 8'h00}},
      '{'{CMD_TRYWAIT,  4'd0,  16'h0000, 1'b0, 8'h06}, 4'd1, 1'b1,
        '{STAT_OK,      4'd0,  1'b0, 8'h00}},
      '{'{CMD_WAIT,     4'd1,  16'h0000, 1'b0, 8'hFF}, 4'd1, 1'b1,
        '{STAT_BLOCKED, 4'd0,  1'b0, 8'h00}},
      '{'{CMD_WAIT,     4'd1,  16'h0000, 1'b0, 8'h00}, 4'd7, 1'b1,
        '{STAT_BLOCKED, 4'd0,  1'b0, 8'h00}},
      '{'{CMD_WAIT,     4'd1,  16'h0000, 1'b0, 8'h11}, 4'd1, 1'b1,
        '{STAT_QUEUE_FULL, 4'd0, 1'b0, 8'h00}},
      '{'{CMD_POST,     4'd1,  16'h0000, 1'b0, 8'h22}, 4'd1, 1'b1,
        '{STAT_OK,      4'd0,  1'b1, 8'hFF}},
      '{'{CMD_POST,     4'd1,  16'h0000, 1'b0, 8'h33}, 4'd1, 1'b1,
        '{STAT_OK,      4'd0,  1'b1, 8'h00}},
      // delete with six tasks still queued
      '{'{CMD_DELETE,   4'd1,  16'h0000, 1'b0, 8'h00}, 4'd1, 1'b1,
        '{STAT_OK,      4'd0,  1'b0, 8'h00}},
      '{'{CMD_POST,     4'd1,  16'h0000, 1'b0, 8'h00}, 4'd1, 1'b1,
        '{STAT_NO_SEM,  4'd0,  1'b0, 8'h00}},
      '{'{CMD_CREATE,   4'd0,  16'h0000, 1'b0, 8'h00}, 4'd14, 1'b0, '0},
      '{'{CMD_CREATE,   4'd0,  16'h0007, 1'b1, 8'h00}, 4'd1, 1'b1,
        '{STAT_NO_SLOT, 4'd0,  1'b0, 8'h00}},
      '{'{CMD_DELETE,   4'd15, 16'h0000, 1'b0, 8'h00}, 4'd1, 1'b1,
        '{STAT_OK,      4'd0,  1'b0, 8'h00}}
   };

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // local copy of the semaphore table
   logic                    sem_used    [NUM_SEMS_DEF];
   logic                    sem_kind    [NUM_SEMS_DEF];
   logic [15:0]             tbl_count   [NUM_SEMS_DEF];
   logic [TASK_W-1:0]       waiter_task [NUM_SEMS_DEF][WAIT_DEPTH_DEF];
   logic [HEAD_W-1:0]       waiter_rd   [NUM_SEMS_DEF];
   logic [HEAD_W:0]         waiter_cnt  [NUM_SEMS_DEF];

   rsp_type rsp_expected_q [$];
   int      mismatch_cnt = 0;
   int      idle_pct     = 20;
   logic    quiet_tail   = 1'b0;
   int      ready_hold   = 0;

   semaphore_table_engine_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic logic sem_take(input logic [3:0] s);
      if (!sem_kind[s] && tbl_count[s] != '0) begin
         tbl_count[s] = tbl_count[s] - 16'd1;
         return 1'b1;
      end
      // binary: only a value of exactly one can be taken
      if (sem_kind[s] && tbl_count[s] == 16'd1) begin
         tbl_count[s] = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic rsp_type sem_table_apply(input req_type r);
      rsp_type           o;
      logic [3:0]        s;
      logic              found;
      logic [HEAD_W-1:0] pos;
      o     = '0;
      s     = r.sem_id;
      found = 1'b0;
      if (r.cmd == CMD_CREATE) begin
         o.status = STAT_NO_SLOT;
         for (int i = 0; i < NUM_SEMS_DEF; i++) begin
            if (!found && !sem_used[i]) begin
               found         = 1'b1;
               sem_used[i]   = 1'b1;
               sem_kind[i]   = r.sem_kind;
               tbl_count[i]  = r.init_count;
               waiter_rd[i]  = '0;
               waiter_cnt[i] = '0;
               o.new_id      = 4'(i);
               o.status      = STAT_OK;
            end
         end
      end else if (r.cmd > CMD_POST || !sem_used[s]) begin
         o.status = STAT_NO_SEM;
      end else begin
         case (r.cmd)
            CMD_DELETE: begin
               sem_used[s]   = 1'b0;
               sem_kind[s]   = 1'b0;
               tbl_count[s]  = '0;
               waiter_rd[s]  = '0;
               waiter_cnt[s] = '0;
            end
            CMD_WAIT: begin
               if (!sem_take(s)) begin
                  if (waiter_cnt[s] == WAIT_DEPTH_DEF) begin
                     o.status = STAT_QUEUE_FULL;
                  end else begin
                     pos                 = waiter_rd[s] + waiter_cnt[s][HEAD_W-1:0];
                     waiter_task[s][pos] = r.task_id;
                     waiter_cnt[s]       = waiter_cnt[s] + 1'b1;
                     o.status            = STAT_BLOCKED;
                  end
               end
            end
            CMD_TRYWAIT: begin
               if (!sem_take(s)) o.status = STAT_BLOCKED;
            end
            default: begin
               if (waiter_cnt[s] != '0) begin
                  o.woke_valid  = 1'b1;
                  o.woke_task   = waiter_task[s][waiter_rd[s]];
                  waiter_rd[s]  = waiter_rd[s] + 1'b1;
                  waiter_cnt[s] = waiter_cnt[s] - 1'b1;
               end else if (!sem_kind[s]) begin
                  if (tbl_count[s] != COUNT_TOP) tbl_count[s] = tbl_count[s] + 16'd1;
               end else begin
                  tbl_count[s] = 16'd1;
               end
            end
         endcase
      end
      return o;
   endfunction

   task automatic send_cmd(input req_type r, input logic typed, input rsp_type want);
      rsp_type model_rsp;
      if (!quiet_tail && $urandom_range(1, 100) <= idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      model_rsp = sem_table_apply(r);
      rsp_expected_q.push_back(typed ? want : model_rsp);
   endtask

   // result side back-pressure
   always @(posedge clock) begin
      if (quiet_tail) begin
         ready_hold = 0;
         rsp_ready <= 1'b1;
      end else if (ready_hold != 0) begin
         ready_hold = ready_hold - 1;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(1, 100) <= idle_pct) begin
         ready_hold = $urandom_range(0, 5);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (rsp_expected_q.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
               $display("%0t: unexpected transaction, status %0d id %0d woke %0b/%0h",
                        $time, rsp_data.status, rsp_data.new_id, rsp_data.woke_valid,
                        rsp_data.woke_task);
         end else begin
            want = rsp_expected_q.pop_front();
            if (rsp_data.status !== want.status || rsp_data.new_id !== want.new_id ||
                rsp_data.woke_valid !== want.woke_valid ||
                rsp_data.woke_task !== want.woke_task) begin
               mismatch_cnt++;
               if (mismatch_cnt <= 10)
                  $display("%0t: expected status %0d id %0d woke %0b/%0h, got %0d %0d %0b/%0h",
                           $time, want.status, want.new_id, want.woke_valid, want.woke_task,
                           rsp_data.status, rsp_data.new_id, rsp_data.woke_valid,
                           rsp_data.woke_task);
            end
         end
      end
   end

   initial begin
      req_type r;
      int      live_ids [$];
      int      roll;
      int      create_pct;
      int      wait_pct;
      logic    wait_heavy;
      for (int i = 0; i < NUM_SEMS_DEF; i++) begin
         sem_used[i]   = 1'b0;
         sem_kind[i]   = 1'b0;
         tbl_count[i]  = '0;
         waiter_rd[i]  = '0;
         waiter_cnt[i] = '0;
      end
      wait_heavy = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int k = 0; k < $size(DIR_TAB); k++)
         for (int n = 0; n < DIR_TAB[k].reps; n++)
            send_cmd(DIR_TAB[k].req, DIR_TAB[k].typed, DIR_TAB[k].rsp);

      for (int k = 0; k < RAND_ITEMS; k++) begin
         if (k % 100 == 0) begin
            // hold off until every outstanding transaction has returned
            req_valid <= 1'b0;
            @(posedge clock);
            while (rsp_expected_q.size() != 0) @(posedge clock);
            case ($urandom_range(0, 2))
               0:       idle_pct = 0;
               1:       idle_pct = 20;
               default: idle_pct = 50;
            endcase
            wait_heavy = 1'($urandom_range(0, 1));
         end
         quiet_tail = (k >= RAND_ITEMS - TAIL_ITEMS);

         live_ids.delete();
         for (int i = 0; i < NUM_SEMS_DEF; i++)
            if (sem_used[i]) live_ids.push_back(i);
         create_pct = (live_ids.size() < 4) ? 35 : (live_ids.size() > 12) ? 5 : 12;
         wait_pct   = wait_heavy ? 55 : 30;

         r.sem_id   = 4'($urandom_range(0, NUM_SEMS_DEF - 1));
         r.sem_kind = 1'($urandom_range(0, 1));
         r.task_id  = 8'($urandom_range(0, 255));
         case ($urandom_range(0, 5))
            0:       r.init_count = '0;
            1:       r.init_count = 16'd1;
            2:       r.init_count = COUNT_TOP;
            3:       r.init_count = COUNT_TOP - 16'd1;
            4:       r.init_count = 16'($urandom_range(2, 9));
            default: r.init_count = 16'($urandom);
         endcase
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            r.cmd = 3'($urandom_range(CMD_UNDEF_LO, CMD_UNDEF_HI));
         end else if (roll < 3 + create_pct) begin
            r.cmd = CMD_CREATE;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 6)                  r.cmd = CMD_DELETE;
            else if (roll < 6 + wait_pct)  r.cmd = CMD_WAIT;
            else if (roll < 21 + wait_pct) r.cmd = CMD_TRYWAIT;
            else                           r.cmd = CMD_POST;
            // mostly aim at live semaphores so the queues actually fill
            if (live_ids.size() != 0 && $urandom_range(0, 99) < 85)
               r.sem_id = 4'(live_ids[$urandom_range(0, live_ids.size() - 1)]);
         end
         send_cmd(r, 1'b0, '0);
      end

      req_valid <= 1'b0;
      while (rsp_expected_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_cnt == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
